@@ src/stni_pkg.sv @@
// Shared types and constants of the steer table interpolation block.
package stni_pkg;

  localparam int ROWS_DEF = 16;
  localparam int COLS_DEF = 16;
  localparam int DW       = 16;
  localparam int CNTW     = 5;
  localparam int DIFW     = 18;
  localparam int NUMW     = 36;
  localparam int DENW     = 17;

  typedef enum logic [1:0] {
    OP_VEL   = 2'd0,
    OP_STEER = 2'd1,
    OP_CELL  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COL_RD,
    S_COL_CMP,
    S_ROW_RD,
    S_ROW_CMP,
    S_ROW_END,
    S_LO_WT,
    S_HI_WT,
    S_Y0_WT,
    S_Y1_WT,
    S_MUL,
    S_DIV_GO,
    S_DIV_WT,
    S_FIN
  } st_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/stni_ram.sv @@
// Generic single write port RAM with registered read.
module stni_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ src/stni_absdiff.sv @@
// Shared distance unit: absolute difference and compare against the best so far.
module stni_absdiff (
  input  logic signed [stni_pkg::DIFW-1:0] a_i,
  input  logic signed [stni_pkg::DIFW-1:0] b_i,
  input  logic        [stni_pkg::DIFW-1:0] best_i,
  output logic        [stni_pkg::DIFW-1:0] dist_o,
  output logic                             less_o
);
  import stni_pkg::*;
  logic signed [DIFW:0] diff;
  logic        [DIFW:0] mag;

  // form the distance and compare
  always_comb begin
    diff   = (DIFW+1)'(a_i) - (DIFW+1)'(b_i);
    mag    = diff[DIFW] ? -diff : diff;
    dist_o = mag[DIFW-1:0];
    less_o = (mag[DIFW-1:0] < best_i);
  end
endmodule

@@ src/stni_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module stni_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [stni_pkg::NUMW-1:0]  num_i,
  input  logic [stni_pkg::DENW-1:0]  den_i,
  output logic [stni_pkg::NUMW-1:0]  quot_o,
  output stni_pkg::div_stat_t        stat_o
);
  import stni_pkg::*;
  localparam int CW = $clog2(NUMW + 1);

  logic [NUMW-1:0] nq_q;
  logic [DENW-1:0] den_q;
  logic [DENW-1:0] rem_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DENW:0]   trial;
  logic            fits;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    trial = {rem_q, nq_q[NUMW-1]};
    fits  = (trial >= {1'b0, den_q});
  end

  // step the division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUMW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // hold numerator/quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      nq_q  <= {nq_q[NUMW-2:0], fits};
      rem_q <= fits ? DENW'(trial - {1'b0, den_q}) : trial[DENW-1:0];
    end
  end

  assign quot_o      = nq_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

@@ src/steer_table_nearest_interp_core.sv @@
// Steer table: nearest velocity column, nearest accel cell, linear interpolation.
//
// Input channel (in_valid_i / in_ready_o) carries one word: a header write,
// a cell write or a query, chosen by opcode_i. Writes complete in the cycle
// they are accepted and give no result. A query gives one result word on the
// output channel (out_valid_o / out_ready_i): steer_angle_o and table_ready_o.
// Configuration writes (cfg_valid_i, always ready) set row_count and
// col_count; write them only while the block is idle.
// A query scans the velocity header and then the chosen column through the
// shared distance unit and registered RAM reads, and runs the serial divider
// when it interpolates. A table that is not loaded skips the scan and the
// divider and answers zero. in_ready_o is low while a query
// runs. The result sits in an output register; if the receiver stalls, the
// block holds the word and waits before accepting the next query result.
// Reset clears the counts, the cell valid bits and both channels; headers
// and cells hold anything until written.
module steer_table_nearest_interp_core #(
  parameter int ROWS = stni_pkg::ROWS_DEF,
  parameter int COLS = stni_pkg::COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic        [stni_pkg::CNTW-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic        [1:0]                 opcode_i,
  input  logic        [3:0]                 row_index_i,
  input  logic        [3:0]                 col_index_i,
  input  logic signed [stni_pkg::DW-1:0]    table_value_i,
  input  logic                              cell_present_i,
  input  logic signed [stni_pkg::DW-1:0]    accel_i,
  input  logic signed [stni_pkg::DW-1:0]    velocity_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [stni_pkg::DW-1:0]    steer_angle_o,
  output logic                              table_ready_o
);
  import stni_pkg::*;

  localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int NCELL = ROWS * COLS;
  localparam int AW  = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int RCW = $clog2(ROWS + 1);
  localparam int CCW = $clog2(COLS + 1);

  st_e state_q, state_d;

  logic [CNTW-1:0] row_count_q, col_count_q;
  logic [NCELL-1:0] valid_q;
  logic [RCW-1:0] nr, rcnt_q, len_q;
  logic [CCW-1:0] nc, ccnt_q;
  logic [CAW-1:0] best_c_q;
  logic [RAW-1:0] best_r_q, oth_q;
  logic [DIFW-1:0] best_d_q;
  logic [DW:0] x_q;
  logic signed [DW-1:0] vel_q, x0_q, lo_q, x1_q, y0_q, y1_q;
  logic neg_q, tbl_q, sgn_q;
  logic signed [34:0] prod_q;
  logic [DENW-1:0] den_q;
  logic [NUMW-1:0] q_q;
  logic out_valid_q, tr_q;
  logic signed [DW-1:0] steer_q;

  logic in_acc, is_query, row_ok, col_ok, loaded, out_free;
  logic [AW-1:0] cell_waddr, cell_raddr, cur_cell;
  logic [CAW-1:0] vel_raddr;
  logic [RAW-1:0] steer_raddr;
  logic [DW-1:0] vel_rdata, steer_rdata, cell_rdata;
  logic vel_we, steer_we, cell_we;
  logic row_stop;
  logic signed [DIFW-1:0] cmp_a, cmp_b;
  logic [DIFW-1:0] cmp_d;
  logic cmp_less;
  logic div_start;
  logic [NUMW-1:0] div_num, div_q;
  div_stat_t div_stat;
  logic signed [DW+1:0] dx;
  logic signed [DW:0] dy, dden;
  logic signed [NUMW+1:0] res, res_s;
  logic signed [DW-1:0] res_sat;
  logic [34:0] prod_mag;

  function automatic logic [AW-1:0] cell_at(input logic [RAW-1:0] r, input logic [CAW-1:0] c);
    cell_at = AW'(int'(r) * COLS + int'(c));
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_query    = (op_e'(opcode_i) == OP_QUERY);
  assign row_ok      = (int'(row_index_i) < ROWS);
  assign col_ok      = (int'(col_index_i) < COLS);
  assign nr = (int'(row_count_q) > ROWS) ? RCW'(ROWS) : RCW'(row_count_q);
  assign nc = (int'(col_count_q) > COLS) ? CCW'(COLS) : CCW'(col_count_q);
  assign loaded   = (nr != '0) && (nc != '0);
  assign out_free = !out_valid_q || out_ready_i;

  // write enables from accepted write words
  assign vel_we     = in_acc && (op_e'(opcode_i) == OP_VEL) && col_ok;
  assign steer_we   = in_acc && (op_e'(opcode_i) == OP_STEER) && row_ok;
  assign cell_we    = in_acc && (op_e'(opcode_i) == OP_CELL) && row_ok && col_ok;
  assign cell_waddr = AW'(int'(row_index_i) * COLS + int'(col_index_i));

  // column stop test for the row scan
  assign cur_cell = cell_at(rcnt_q[RAW-1:0], best_c_q);
  assign row_stop = (rcnt_q == nr) || !valid_q[cur_cell];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_acc && is_query) state_d = loaded ? S_COL_RD : S_FIN;
      S_COL_RD:  state_d = S_COL_CMP;
      S_COL_CMP: state_d = ((ccnt_q + 1'b1) == nc) ? S_ROW_RD : S_COL_RD;
      S_ROW_RD:  state_d = row_stop ? S_ROW_END : S_ROW_CMP;
      S_ROW_CMP: state_d = S_ROW_RD;
      S_ROW_END: begin
        if (len_q == '0 || best_r_q == '0 || (RCW'(best_r_q) + RCW'(1)) == len_q) begin
          state_d = S_Y0_WT;
        end else begin
          state_d = S_LO_WT;
        end
      end
      S_LO_WT:   state_d = S_HI_WT;
      S_HI_WT:   state_d = S_Y0_WT;
      S_Y0_WT:   state_d = tbl_q ? S_FIN : S_Y1_WT;
      S_Y1_WT:   state_d = S_MUL;
      S_MUL:     state_d = (x1_q == x0_q) ? S_FIN : S_DIV_GO;
      S_DIV_GO:  state_d = S_DIV_WT;
      S_DIV_WT:  if (div_stat.done) state_d = S_FIN;
      S_FIN:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // RAM read addresses and shared unit operands
  always_comb begin
    vel_raddr   = ccnt_q[CAW-1:0];
    cell_raddr  = cur_cell;
    steer_raddr = best_r_q;
    cmp_a       = DIFW'($signed(cell_rdata));
    cmp_b       = $signed({{(DIFW-DW-1){1'b0}}, x_q});
    div_start   = 1'b0;
    case (state_q)
      S_COL_CMP: begin
        cmp_a = DIFW'($signed(vel_rdata));
        cmp_b = DIFW'(vel_q);
      end
      S_ROW_END: begin
        cell_raddr  = cell_at(best_r_q - 1'b1, best_c_q);
        steer_raddr = (len_q == '0) ? '0 : best_r_q;
      end
      S_LO_WT:   cell_raddr = cell_at(best_r_q + 1'b1, best_c_q);
      S_HI_WT:   steer_raddr = best_r_q;
      S_Y0_WT:   steer_raddr = oth_q;
      S_DIV_GO:  div_start = 1'b1;
      default: begin
        vel_raddr = ccnt_q[CAW-1:0];
      end
    endcase
  end

  stni_ram #(.WIDTH(DW), .DEPTH(COLS), .AW(CAW)) u_vel_ram (
    .clk_i, .we_i(vel_we), .waddr_i(CAW'(col_index_i)), .wdata_i(table_value_i),
    .raddr_i(vel_raddr), .rdata_o(vel_rdata)
  );
  stni_ram #(.WIDTH(DW), .DEPTH(ROWS), .AW(RAW)) u_steer_ram (
    .clk_i, .we_i(steer_we), .waddr_i(RAW'(row_index_i)), .wdata_i(table_value_i),
    .raddr_i(steer_raddr), .rdata_o(steer_rdata)
  );
  stni_ram #(.WIDTH(DW), .DEPTH(NCELL), .AW(AW)) u_cell_ram (
    .clk_i, .we_i(cell_we), .waddr_i(cell_waddr), .wdata_i(table_value_i),
    .raddr_i(cell_raddr), .rdata_o(cell_rdata)
  );

  stni_absdiff u_dist (
    .a_i(cmp_a), .b_i(cmp_b), .best_i(best_d_q), .dist_o(cmp_d), .less_o(cmp_less)
  );

  // interpolation operands
  always_comb begin
    dx       = $signed({1'b0, x_q}) - (DW+2)'(x0_q);
    dy       = (DW+1)'(y1_q) - (DW+1)'(y0_q);
    dden     = (DW+1)'(x1_q) - (DW+1)'(x0_q);
    prod_mag = prod_q[34] ? 35'(-prod_q) : 35'(prod_q);
    div_num  = NUMW'(prod_mag) + NUMW'(den_q >> 1);
  end

  stni_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(den_q),
    .quot_o(div_q), .stat_o(div_stat)
  );

  // final sum, sign and saturation
  always_comb begin
    res   = sgn_q ? ((NUMW+2)'(y0_q) - $signed({2'b00, q_q}))
                  : ((NUMW+2)'(y0_q) + $signed({2'b00, q_q}));
    res_s = neg_q ? -res : res;
    if (res_s > (NUMW+2)'(32767)) begin
      res_sat = 16'sh7fff;
    end else if (res_s < -(NUMW+2)'(32768)) begin
      res_sat = -16'sh8000;
    end else begin
      res_sat = res_s[DW-1:0];
    end
  end

  // control state, counts and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_count_q <= '0;
      col_count_q <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ROW_COUNT) row_count_q <= cfg_data_i;
        if (cfg_index_i == REG_COL_COUNT) col_count_q <= cfg_data_i;
      end
      if (cell_we) valid_q[cell_waddr] <= cell_present_i;
      if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ccnt_q <= '0;
        rcnt_q <= '0;
        vel_q  <= velocity_i;
        neg_q  <= accel_i[DW-1];
        x_q    <= accel_i[DW-1] ? -(DW+1)'(accel_i) : (DW+1)'(accel_i);
        tbl_q  <= !loaded;
        y0_q   <= '0;
        q_q    <= '0;
        sgn_q  <= 1'b0;
      end
      S_COL_CMP: begin
        if (ccnt_q == '0 || cmp_less) begin
          best_d_q <= cmp_d;
          best_c_q <= ccnt_q[CAW-1:0];
        end
        ccnt_q <= ccnt_q + 1'b1;
      end
      S_ROW_RD: begin
        if (row_stop) len_q <= rcnt_q;
      end
      S_ROW_CMP: begin
        if (rcnt_q == '0 || cmp_less) begin
          best_d_q <= cmp_d;
          best_r_q <= rcnt_q[RAW-1:0];
          x0_q     <= $signed(cell_rdata);
        end
        rcnt_q <= rcnt_q + 1'b1;
      end
      S_ROW_END: begin
        tbl_q <= (len_q == '0 || best_r_q == '0 ||
                  (RCW'(best_r_q) + RCW'(1)) == len_q);
      end
      S_LO_WT: begin
        lo_q     <= $signed(cell_rdata);
        best_d_q <= cmp_d;
      end
      S_HI_WT: begin
        if (cmp_less) begin
          oth_q <= best_r_q + 1'b1;
          x1_q  <= $signed(cell_rdata);
        end else begin
          oth_q <= best_r_q - 1'b1;
          x1_q  <= lo_q;
        end
      end
      S_Y0_WT: y0_q <= $signed(steer_rdata);
      S_Y1_WT: y1_q <= $signed(steer_rdata);
      S_MUL: begin
        prod_q <= 35'(dx * dy);
        den_q  <= dden[DW] ? DENW'(-dden) : DENW'(dden);
        sgn_q  <= dden[DW] ^ ((dx < 0) != (dy < 0));
      end
      S_DIV_WT: if (div_stat.done) q_q <= div_q;
      S_FIN: begin
        if (out_free) begin
          steer_q <= tbl_q && (nr == '0 || nc == '0) ? '0 : res_sat;
          tr_q    <= loaded;
        end
      end
      default: begin
        ccnt_q <= ccnt_q;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign steer_angle_o = steer_q;
  assign table_ready_o = tr_q;
endmodule

@@ src/stni_checker.sv @@
// Port-level checks for the steer table block, bound to the top level.
module stni_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  opcode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] steer_angle_o,
  input logic        table_ready_o
);
  import stni_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(steer_angle_o))
    else $error("result word changed while stalled");

  // a query blocks the input while it runs
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_e'(opcode_i) == OP_QUERY) |=> !in_ready_o)
    else $error("input ready during query");

  // a result appears only after a query held the input
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without query");

  // an unloaded table answers zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !table_ready_o |-> steer_angle_o == 16'h0000)
    else $error("nonzero steer from unloaded table");
endmodule

bind steer_table_nearest_interp_core stni_checker u_stni_checker (.*);

@@ verif/steer_table_nearest_interp_core_test.sv @@
// Testbench for the steer table interpolation core: queued driver, monitor and predictor.
`timescale 1ns / 100ps

module steer_table_nearest_interp_core_test;
  import stni_pkg::*;

  localparam int NR = 16;
  localparam int NC = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] tv;
    logic        present;
    logic [15:0] accel;
    logic [15:0] vel;
  } word_t;

  typedef struct packed {
    logic [15:0] steer;
    logic        ready;
  } answer_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [CNTW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] opcode_i;
  logic [3:0] row_index_i, col_index_i;
  logic signed [15:0] table_value_i, accel_i, velocity_i;
  logic cell_present_i;
  logic out_valid_o, out_ready_i;
  logic signed [15:0] steer_angle_o;
  logic table_ready_o;

  steer_table_nearest_interp_core i_dut (.*);

  // Predictor state
  int vel_hdr[NC];
  int steer_hdr[NR];
  int cells[NR*NC];
  bit valid_bits[NR*NC];
  int rows_used, cols_used;

  word_t   pending_words[$];
  answer_t expected_answers[$];
  int errors;
  int idle_cycles;
  bit feed_done;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int absd(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint lerp(int x, int x0, int x1, int y0, int y1);
    longint num, den, mag, q;
    if (x1 == x0) return y0;
    num = longint'(x - x0) * longint'(y1 - y0);
    den = x1 - x0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    if (num < 0) q = -q;
    return y0 + q;
  endfunction

  // Update the table copy, or compute the answer of a query
  function automatic void predict_word(word_t w);
    int nr, nc, x, bc, bd, d, len, br, oth, lo, hi, acc;
    longint st;
    answer_t a;
    case (op_e'(w.op))
      OP_VEL: vel_hdr[w.col] = $signed(w.tv);
      OP_STEER: steer_hdr[w.row] = $signed(w.tv);
      OP_CELL: begin
        cells[w.row*NC + w.col] = $signed(w.tv);
        valid_bits[w.row*NC + w.col] = w.present;
      end
      default: begin
        nr = rows_used > NR ? NR : rows_used;
        nc = cols_used > NC ? NC : cols_used;
        if (nr == 0 || nc == 0) begin
          a.steer = '0;
          a.ready = 1'b0;
        end else begin
          acc = $signed(w.accel);
          x = acc < 0 ? -acc : acc;
          bc = 0;
          bd = absd(vel_hdr[0], $signed(w.vel));
          for (int i = 1; i < nc; i++) begin
            d = absd(vel_hdr[i], $signed(w.vel));
            if (d < bd) begin
              bd = d;
              bc = i;
            end
          end
          len = 0;
          while (len < nr && valid_bits[len*NC + bc]) len++;
          if (len == 0) st = steer_hdr[0];
          else begin
            br = 0;
            bd = absd(cells[bc], x);
            for (int i = 1; i < len; i++) begin
              d = absd(cells[i*NC + bc], x);
              if (d < bd) begin
                bd = d;
                br = i;
              end
            end
            if (br == 0 || br == len - 1) st = steer_hdr[br];
            else begin
              lo = cells[(br-1)*NC + bc];
              hi = cells[(br+1)*NC + bc];
              oth = (absd(hi, x) < absd(lo, x)) ? br + 1 : br - 1;
              st = lerp(x, cells[br*NC + bc], cells[oth*NC + bc],
                        steer_hdr[br], steer_hdr[oth]);
            end
          end
          if (acc < 0) st = -st;
          if (st > 32767) st = 32767;
          if (st < -32768) st = -32768;
          a.steer = st[15:0];
          a.ready = 1'b1;
        end
        expected_answers.push_back(a);
      end
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: present queued words at the falling edge after a random gap
  int drv_gap;
  initial drv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        // accepted at the last rising edge; already handled there
      end
    end
  end
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // nothing
    end else if (in_valid_i && in_ready_o) begin
      predict_word(pending_words.pop_front());
    end
  end
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || (in_valid_i && accepted_in)) begin
      if (drv_gap > 0) begin
        drv_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0 && !hold_feed) begin
        in_valid_i <= 1'b1;
        opcode_i <= pending_words[0].op;
        row_index_i <= pending_words[0].row;
        col_index_i <= pending_words[0].col;
        table_value_i <= pending_words[0].tv;
        cell_present_i <= pending_words[0].present;
        accel_i <= pending_words[0].accel;
        velocity_i <= pending_words[0].vel;
        drv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) drv_gap = 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Flag acceptance at the rising edge so the driver can advance
  bit accepted_in, hold_feed;
  always @(posedge clk_i) accepted_in <= in_valid_i && in_ready_o;

  // Monitor: check result words and pace the receiver
  int rcv_gap;
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) report("unexpected result", steer_angle_o, 0);
      else begin
        e = expected_answers.pop_front();
        if (steer_angle_o !== $signed(e.steer)) report("steer_angle", steer_angle_o,
                                                      $signed(e.steer));
        if (table_ready_o !== e.ready) report("table_ready", table_ready_o, e.ready);
      end
    end
  end
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (rcv_gap > 0) begin
      rcv_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (out_valid_o && out_ready_i)
        rcv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
    end
  end

  // Watchdog on cycles without any acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
        $display("steer_table_nearest_interp_core_test: done, errors");
        $finish;
      end
    end
  end

  task automatic push(logic [1:0] op, int r, int c, int tv, bit p, int a, int v);
    word_t w;
    w.op = op; w.row = r; w.col = c; w.tv = tv; w.present = p;
    w.accel = a; w.vel = v;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(bit idx, int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_used = val; else cols_used = val;
  endtask

  // Fill a table: sorted velocity header, steer header, non-decreasing cells (random cells when noisy)
  task automatic load_table(int nr, int nc, bit noisy);
    int base;
    for (int c = 0; c < NC; c++) push(OP_VEL, $urandom, c, c*300 - 2000 + $urandom_range(0, 200),
                                      $urandom, $urandom, $urandom);
    for (int r = 0; r < NR; r++) push(OP_STEER, r, $urandom, $urandom, $urandom, $urandom,
                                      $urandom);
    for (int c = 0; c < NC; c++) begin
      base = $urandom_range(0, 300);
      for (int r = 0; r < NR; r++) begin
        base += noisy ? $urandom_range(0, 4) : $urandom_range(0, 2000);
        push(OP_CELL, r, c, noisy ? $urandom : base,
             (r < nr && $urandom_range(0, 30) != 0) || (r >= nr && $urandom_range(0, 1)),
             $urandom, $urandom);
      end
    end
  endtask

  task automatic queries(int n);
    for (int i = 0; i < n; i++)
      case ($urandom_range(0, 5))
        0: push(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: push(OP_QUERY, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 1) ? 16'h8000 : 16'h7fff, $urandom);
        default: push(OP_QUERY, $urandom, $urandom, $urandom, $urandom,
                      $signed($urandom_range(0, 40000)) - 20000,
                      $signed($urandom_range(0, 8000)) - 3000);
      endcase
  endtask

  initial begin
    int settings[6][2];
    errors = 0; idle_cycles = 0;
    rows_used = 0; cols_used = 0;
    foreach (valid_bits[i]) valid_bits[i] = 0;
    rcv_gap = 0; hold_feed = 0;
    cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    in_valid_i = 0; out_ready_i = 0;
    opcode_i = 0; row_index_i = 0; col_index_i = 0; table_value_i = 0;
    cell_present_i = 0; accel_i = 0; velocity_i = 0;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    rst_ni = 1;
    // Directed: unloaded table, then a loaded one at its extremes
    push(OP_QUERY, 0, 0, 0, 0, 16'h7fff, 16'h8000);
    push(OP_QUERY, 15, 15, 16'hffff, 1, 16'h8000, 16'h7fff);
    wait_drained();
    write_reg(REG_ROW_COUNT, 16);
    write_reg(REG_COL_COUNT, 16);
    load_table(16, 16, 0);
    push(OP_QUERY, 0, 0, 0, 0, 0, 0);
    push(OP_QUERY, 0, 0, 0, 0, 16'h7fff, 16'h7fff);
    push(OP_QUERY, 0, 0, 0, 0, 16'h8000, 16'h8000);
    push(OP_QUERY, 0, 0, 0, 0, -500, 100);
    // Empty column and equal-x cells in column 0
    push(OP_CELL, 0, 0, 0, 0, 0, 0);
    push(OP_QUERY, 0, 0, 0, 0, 300, -32768);
    push(OP_CELL, 0, 0, 100, 1, 0, 0);
    push(OP_CELL, 1, 0, 400, 1, 0, 0);
    push(OP_CELL, 2, 0, 400, 1, 0, 0);
    push(OP_QUERY, 0, 0, 0, 0, 350, -32768);
    push(OP_STEER, 0, 0, 16'h8000, 0, 0, 0);
    push(OP_STEER, 1, 0, 16'h7fff, 0, 0, 0);
    push(OP_QUERY, 0, 0, 0, 0, -120, -32768);
    wait_drained();
    // Sweep row and column count settings; after each batch, pause the sender until every expected result has come
    settings = '{'{16,16}, '{31,31}, '{1,16}, '{16,1}, '{0,5}, '{5,17}};
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_ROW_COUNT, settings[s][0]);
      write_reg(REG_COL_COUNT, settings[s][1]);
      for (int rep = 0; rep < 2; rep++) begin
        load_table(settings[s][0] > 16 ? 16 : settings[s][0], 16, (s + rep) % 4 == 3);
        queries(40);
        wait_drained();
      end
    end
    feed_done = 1;
    wait_drained();
    if (errors == 0) $display("steer_table_nearest_interp_core_test: done, clean");
    else $display("steer_table_nearest_interp_core_test: done, errors");
    $finish;
  end

endmodule
